### design/u8u16_pkg.sv
// u8u16_pkg: shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies; used by every module of the block

package u8u16_pkg;

    // input word: one utf-8 byte and the end-of-text flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in;

    // output word: one utf-16 code unit and the last-of-byte flag
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
    } t_out;

    // decoded job: the code units that one input byte gives, oldest in slot 0
    typedef struct packed {
        logic [2:0]       unit_cnt;
        logic [3:0][15:0] units;
    } t_job;

    // default job queue depth
    localparam int JOB_DEPTH_DEF = 4;

    // code points and byte ranges
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [7:0]  ASCII_LIM   = 8'h80;
    localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
    localparam logic [7:0]  LEAD2_MAX   = 8'hDF;
    localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
    localparam logic [7:0]  LEAD3_MAX   = 8'hEF;
    localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
    localparam logic [7:0]  LEAD4_MAX   = 8'hF4;
    localparam logic [20:0] MIN_CP2     = 21'h00080;
    localparam logic [20:0] MIN_CP3     = 21'h00800;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST  = 21'h0D800;
    localparam logic [20:0] SURR_END    = 21'h0DFFF;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;

endpackage

### design/u8u16_front.sv
// u8u16_front: decode state and per-byte classification into a job of code units
// depends on u8u16_pkg

module u8u16_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  u8u16_pkg::t_in   i_item,
    output logic             o_job_wr,
    output u8u16_pkg::t_job  o_job
);

    logic [1:0]  r_exp, n_exp;
    logic [1:0]  r_rcv, n_rcv;
    logic [20:0] r_val, n_val;

    logic [7:0]       b;
    logic             cont;
    logic [20:0]      shifted;
    logic [20:0]      supp;
    logic [1:0]       rcv_inc;
    logic [20:0]      least;
    logic             bad;
    logic             do_lead;
    logic [2:0]       nrep;
    logic [2:0]       cnt;
    logic [3:0][15:0] units;

    assign b       = i_item.data_byte;
    assign cont    = (b[7:6] == 2'b10);
    assign shifted = {r_val[14:0], b[5:0]};
    assign supp    = shifted - u8u16_pkg::SUPP_BASE;
    assign rcv_inc = r_rcv + 2'd1;

    // smallest legal value for the sequence length
    always_comb begin
        case (r_exp)
            2'd1:    least = u8u16_pkg::MIN_CP2;
            2'd2:    least = u8u16_pkg::MIN_CP3;
            default: least = u8u16_pkg::SUPP_BASE;
        endcase
    end

    assign bad = (shifted < least)
               || ((shifted >= u8u16_pkg::SURR_FIRST) && (shifted <= u8u16_pkg::SURR_END))
               || (shifted > u8u16_pkg::CP_MAX);

    // classify the byte and build the list of code units it gives
    always_comb begin
        n_exp   = r_exp;
        n_rcv   = r_rcv;
        n_val   = r_val;
        cnt     = 3'd0;
        units   = {4{u8u16_pkg::REPLACEMENT}};
        do_lead = 1'b0;
        nrep    = 3'd0;

        if (r_exp != 2'd0) begin
            if (cont) begin
                if (rcv_inc == r_exp) begin
                    // sequence complete
                    if (bad) begin
                        nrep = {1'b0, r_exp} + 3'd1;
                        for (int i = 0; i < 4; i++) begin
                            if (3'(i) < nrep) begin
                                units[cnt[1:0]] = u8u16_pkg::REPLACEMENT;
                                cnt = cnt + 3'd1;
                            end
                        end
                    end else if (shifted < u8u16_pkg::SUPP_BASE) begin
                        units[cnt[1:0]] = shifted[15:0];
                        cnt = cnt + 3'd1;
                    end else begin
                        units[cnt[1:0]] = u8u16_pkg::HI_SURR + {6'd0, supp[19:10]};
                        cnt = cnt + 3'd1;
                        units[cnt[1:0]] = u8u16_pkg::LO_SURR + {6'd0, supp[9:0]};
                        cnt = cnt + 3'd1;
                    end
                    n_exp = 2'd0;
                    n_rcv = 2'd0;
                    n_val = '0;
                end else begin
                    n_val = shifted;
                    n_rcv = rcv_inc;
                end
            end else begin
                // interrupted sequence: flush lead and held continuations
                nrep = {1'b0, r_rcv} + 3'd1;
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < nrep) begin
                        units[cnt[1:0]] = u8u16_pkg::REPLACEMENT;
                        cnt = cnt + 3'd1;
                    end
                end
                n_exp   = 2'd0;
                n_rcv   = 2'd0;
                n_val   = '0;
                do_lead = 1'b1;
            end
        end else begin
            do_lead = 1'b1;
        end

        // byte taken as a lead
        if (do_lead) begin
            if (b < u8u16_pkg::ASCII_LIM) begin
                units[cnt[1:0]] = {8'd0, b};
                cnt = cnt + 3'd1;
            end else if ((b >= u8u16_pkg::LEAD2_MIN) && (b <= u8u16_pkg::LEAD2_MAX)) begin
                n_exp = 2'd1;
                n_val = {16'd0, b[4:0]};
            end else if ((b >= u8u16_pkg::LEAD3_MIN) && (b <= u8u16_pkg::LEAD3_MAX)) begin
                n_exp = 2'd2;
                n_val = {17'd0, b[3:0]};
            end else if ((b >= u8u16_pkg::LEAD4_MIN) && (b <= u8u16_pkg::LEAD4_MAX)) begin
                n_exp = 2'd3;
                n_val = {18'd0, b[2:0]};
            end else begin
                units[cnt[1:0]] = u8u16_pkg::REPLACEMENT;
                cnt = cnt + 3'd1;
            end
            n_rcv = 2'd0;
        end

        // end of text with a sequence still open
        if (i_item.end_of_text && (n_exp != 2'd0)) begin
            nrep = {1'b0, n_rcv} + 3'd1;
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < nrep) begin
                    units[cnt[1:0]] = u8u16_pkg::REPLACEMENT;
                    cnt = cnt + 3'd1;
                end
            end
            n_exp = 2'd0;
            n_rcv = 2'd0;
            n_val = '0;
        end
    end

    // job handed to the queue only when the byte gives output
    assign o_job_wr       = i_accept && (cnt != 3'd0);
    assign o_job.unit_cnt = cnt;
    assign o_job.units    = units;

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= 2'd0;
            r_rcv <= 2'd0;
            r_val <= '0;
        end else if (i_accept) begin
            r_exp <= n_exp;
            r_rcv <= n_rcv;
            r_val <= n_val;
        end
    end

endmodule

### design/u8u16_jobq.sv
// u8u16_jobq: short queue of decoded jobs between the front and back parts
// depends on u8u16_pkg

module u8u16_jobq #(
    parameter int DEPTH = u8u16_pkg::JOB_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  u8u16_pkg::t_job  i_job,
    input  logic             i_rd,
    output logic             o_full,
    output logic             o_valid,
    output u8u16_pkg::t_job  o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8u16_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_wr;
    logic            do_rd;

    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // the front only writes when there is room
    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_wr)
        else $error("job written while queue full");

    // occupancy steps up on a write without a read
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("job queue count out of step");

endmodule

### design/u8u16_back.sv
// u8u16_back: walks the head job into the output register, one code unit a cycle
// while that register is empty or popped; depends on u8u16_pkg

module u8u16_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_head_valid,
    input  u8u16_pkg::t_job  i_head,
    output logic             o_head_done,
    input  logic             pop,
    output logic             empty,
    output u8u16_pkg::t_out  o_data
);

    logic            r_ovld;
    u8u16_pkg::t_out r_out;
    logic [1:0]      r_idx;
    logic            load;
    logic            last_unit;

    assign last_unit   = ({1'b0, r_idx} == (i_head.unit_cnt - 3'd1));
    assign load        = i_head_valid && (!r_ovld || pop);
    assign o_head_done = load && last_unit;
    assign empty       = !r_ovld;
    assign o_data      = r_out;

    // unit index within the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (load) begin
            r_idx <= last_unit ? 2'd0 : r_idx + 2'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (load) begin
            r_ovld <= 1'b1;
        end else if (pop) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.code_unit <= i_head.units[r_idx];
            r_out.run_last  <= last_unit;
        end
    end

    // a queued job always carries at least one unit and at most four
    a_job_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ((i_head.unit_cnt != 3'd0) && (i_head.unit_cnt <= 3'd4)))
        else $error("empty or oversized job in queue");

    // index never runs past the head job
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> ({1'b0, r_idx} < i_head.unit_cnt))
        else $error("unit index beyond job");

    // between jobs the index sits at the start
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_idx == 2'd0))
        else $error("unit index not cleared with no job");

endmodule

### design/utf8_to_utf16_transcoder_top.sv
// utf8_to_utf16_transcoder_top: top level of the utf-8 to utf-16 transcoder
// depends on u8u16_pkg, u8u16_front, u8u16_jobq, u8u16_back
//
// Usage
//  Input queue side: one utf-8 byte with an end-of-text flag per word, taken
//  at a clock edge with push high and full low. Output queue side: one utf-16
//  code unit per word, shown while empty is low and taken with pop high.
//  run_last marks the final code unit caused by an input byte; bytes that only
//  extend a pending sequence give no output word.
//  Throughput: one byte per cycle is accepted while the job queue has room;
//  the output side delivers one code unit per cycle while pop is high. Bytes
//  that give two to four units (surrogate pairs, replacement bursts) drain at
//  one unit a cycle while popped; the job queue, JOB_DEPTH jobs deep, absorbs
//  them before full rises. A byte's first unit is written into the job queue
//  at the edge that takes it, then loaded into the output register.
//  Reset (synchronous, active low) clears the decode state, the job queue and
//  the output register; a partly received sequence is dropped silently.
//  When the receiver stalls the output word holds, the job queue fills, and
//  full rises to hold back the sender; nothing is lost.

module utf8_to_utf16_transcoder_top #(
    parameter int JOB_DEPTH = u8u16_pkg::JOB_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  u8u16_pkg::t_in   i_data,
    output logic             empty,
    input  logic             pop,
    output u8u16_pkg::t_out  o_data
);

    logic            accept;
    logic            job_wr;
    u8u16_pkg::t_job job;
    logic            q_full;
    logic            head_valid;
    u8u16_pkg::t_job head;
    logic            head_done;

    assign full   = q_full;
    assign accept = push && !q_full;

    // byte classification and decode state
    u8u16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .o_job_wr (job_wr),
        .o_job    (job)
    );

    // decoupling queue
    u8u16_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_job   (job),
        .i_rd    (head_done),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // code unit serialiser and output register
    u8u16_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_done  (head_done),
        .pop          (pop),
        .empty        (empty),
        .o_data       (o_data)
    );

endmodule

### dv/utf8_to_utf16_transcoder_top_test.sv
// utf8_to_utf16_transcoder_top_test: self-checking bench for the utf-8 to utf-16 transcoder
// drives byte words with random gaps and pops code unit words with random stalls
// depends on u8u16_pkg and utf8_to_utf16_transcoder_top

module utf8_to_utf16_transcoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int RAND_BYTES  = 380;
    localparam int CYCLE_LIMIT = 400000;

    // kinds of random text piece
    typedef enum int {
        PIECE_CHAR,
        PIECE_BYTE,
        PIECE_TRUNC,
        PIECE_BADSEQ,
        PIECE_BROKEN
    } t_piece;

    // expected code units per accepted byte, checked in order of arrival
    class code_unit_scoreboard;
        logic [1:0]        need_cnt;
        logic [1:0]        held_cnt;
        logic [20:0]       gathered;
        logic [15:0]       burst[$];
        u8u16_pkg::t_out   due_units[$];
        int                mismatches;

        function new();
            need_cnt   = '0;
            held_cnt   = '0;
            gathered   = '0;
            mismatches = 0;
        endfunction

        // drop the pending sequence: one replacement for the lead, one per held byte
        function void flush_seq(int held);
            burst.push_back(u8u16_pkg::REPLACEMENT);
            for (int i = 0; i < held; i++) burst.push_back(u8u16_pkg::REPLACEMENT);
            need_cnt = '0;
            held_cnt = '0;
            gathered = '0;
        endfunction

        // decode a byte met with nothing pending
        function void take_lead(logic [7:0] b);
            if (b < u8u16_pkg::ASCII_LIM) begin
                burst.push_back({8'h00, b});
            end else if (b >= u8u16_pkg::LEAD2_MIN && b <= u8u16_pkg::LEAD2_MAX) begin
                need_cnt = 2'd1;
                gathered = {16'h0, b[4:0]};
            end else if (b >= u8u16_pkg::LEAD3_MIN && b <= u8u16_pkg::LEAD3_MAX) begin
                need_cnt = 2'd2;
                gathered = {17'h0, b[3:0]};
            end else if (b >= u8u16_pkg::LEAD4_MIN && b <= u8u16_pkg::LEAD4_MAX) begin
                need_cnt = 2'd3;
                gathered = {18'h0, b[2:0]};
            end else begin
                burst.push_back(u8u16_pkg::REPLACEMENT);
            end
            held_cnt = '0;
        endfunction

        // bmp value or surrogate pair
        function void emit_code_point(logic [20:0] cp);
            logic [20:0] offs;
            if (cp < u8u16_pkg::SUPP_BASE) begin
                burst.push_back(cp[15:0]);
            end else begin
                offs = cp - u8u16_pkg::SUPP_BASE;
                burst.push_back(u8u16_pkg::HI_SURR + {6'h0, offs[19:10]});
                burst.push_back(u8u16_pkg::LO_SURR + {6'h0, offs[9:0]});
            end
        endfunction

        // accepted byte word: work out the code units it gives
        function void note_byte(u8u16_pkg::t_in w);
            logic [20:0]     least;
            logic            bad;
            u8u16_pkg::t_out unit;
            burst.delete();
            if (need_cnt != 0) begin
                if (w.data_byte[7:6] == 2'b10) begin
                    gathered = {gathered[14:0], w.data_byte[5:0]};
                    held_cnt = held_cnt + 2'd1;
                    if (held_cnt >= need_cnt) begin
                        least = (need_cnt == 2'd1) ? u8u16_pkg::MIN_CP2 :
                                (need_cnt == 2'd2) ? u8u16_pkg::MIN_CP3 :
                                u8u16_pkg::SUPP_BASE;
                        bad = (gathered < least) || (gathered > u8u16_pkg::CP_MAX) ||
                              (gathered >= u8u16_pkg::SURR_FIRST &&
                               gathered <= u8u16_pkg::SURR_END);
                        if (bad) begin
                            flush_seq(int'(need_cnt));
                        end else begin
                            emit_code_point(gathered);
                            need_cnt = '0;
                            held_cnt = '0;
                            gathered = '0;
                        end
                    end
                end else begin
                    flush_seq(int'(held_cnt));
                    take_lead(w.data_byte);
                end
            end else begin
                take_lead(w.data_byte);
            end
            if (w.end_of_text && need_cnt != 0) flush_seq(int'(held_cnt));
            for (int i = 0; i < burst.size(); i++) begin
                unit.code_unit = burst[i];
                unit.run_last  = (i == burst.size() - 1);
                due_units.push_back(unit);
            end
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // popped code unit word against the oldest expectation
        task check_unit(u8u16_pkg::t_out got);
            u8u16_pkg::t_out want;
            if (due_units.size() == 0) begin
                report_mismatch($sformatf("unexpected code unit %h", got.code_unit));
            end else begin
                want = due_units.pop_front();
                if (got.code_unit !== want.code_unit)
                    report_mismatch($sformatf("code_unit %h, want %h",
                                              got.code_unit, want.code_unit));
                if (got.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, want %b on unit %h",
                                              got.run_last, want.run_last, want.code_unit));
            end
        endtask
    endclass

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            push    = 1'b0;
    logic            pop     = 1'b0;
    u8u16_pkg::t_in  i_data  = '0;
    logic            full;
    logic            empty;
    u8u16_pkg::t_out o_data;

    code_unit_scoreboard sb;
    logic rst_done   = 1'b0;
    logic no_idle    = 1'b0;
    int   rx_hold    = 0;
    int   cycle_cnt  = 0;
    int   bytes_sent = 0;

    utf8_to_utf16_transcoder_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // run guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: check the popped word, then choose the next pop
    always @(posedge i_clk) begin
        if (rst_done) begin
            if (pop && !empty) sb.check_unit(o_data);
            if (rx_hold > 0) begin
                pop <= 1'b0;
                rx_hold <= rx_hold - 1;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 5) == 0) rx_hold <= idle_len();
            end
        end
    end

    // one byte word through the input handshake
    task drive_byte(input logic [7:0] b, input logic eot);
        int gap;
        u8u16_pkg::t_in w;
        gap = idle_len();
        w.data_byte   = b;
        w.end_of_text = eot;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (full);
        sb.note_byte(w);
        bytes_sent++;
    endtask

    // utf-8 bytes of a code point, lead first
    function automatic int encode_cp(input logic [20:0] cp, output logic [7:0] seq[4]);
        if (cp < 21'h80) begin
            seq[0] = cp[7:0];
            return 1;
        end else if (cp < 21'h800) begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
            return 2;
        end else if (cp < 21'h10000) begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
            return 3;
        end
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    // well-formed code point of random length and content
    function automatic logic [20:0] random_cp();
        logic [20:0] cp;
        case ($urandom_range(0, 3))
            0: cp = 21'($urandom_range(0, 'h7F));
            1: cp = 21'($urandom_range('h80, 'h7FF));
            2: begin
                cp = 21'($urandom_range('h800, 'hF7FF));
                if (cp >= u8u16_pkg::SURR_FIRST) cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // one random piece of text: mostly whole characters, some noise
    task send_piece();
        logic [7:0] seq[4];
        int         len;
        int         r;
        t_piece     kind;
        r = $urandom_range(0, 99);
        kind = (r < 70) ? PIECE_CHAR  : (r < 78) ? PIECE_BYTE :
               (r < 86) ? PIECE_TRUNC : (r < 94) ? PIECE_BADSEQ : PIECE_BROKEN;
        case (kind)
            PIECE_CHAR: begin
                len = encode_cp(random_cp(), seq);
                for (int i = 0; i < len; i++)
                    drive_byte(seq[i], (i == len - 1) && ($urandom_range(0, 19) == 0));
            end
            PIECE_BYTE: begin
                drive_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            PIECE_TRUNC: begin
                do len = encode_cp(random_cp(), seq); while (len < 2);
                len = $urandom_range(1, len - 1);
                for (int i = 0; i < len; i++)
                    drive_byte(seq[i], (i == len - 1) && ($urandom_range(0, 2) == 0));
            end
            PIECE_BADSEQ: begin
                // leads whose gathered value may be overlong, a surrogate or too high
                seq[0] = 8'($urandom_range(u8u16_pkg::LEAD3_MIN, u8u16_pkg::LEAD4_MAX));
                len = (seq[0] < u8u16_pkg::LEAD4_MIN) ? 3 : 4;
                for (int i = 1; i < len; i++) seq[i] = 8'($urandom_range('h80, 'hBF));
                for (int i = 0; i < len; i++)
                    drive_byte(seq[i], (i == len - 1) && ($urandom_range(0, 9) == 0));
            end
            default: begin
                do len = encode_cp(random_cp(), seq); while (len < 2);
                seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
                for (int i = 0; i < len; i++) drive_byte(seq[i], 1'b0);
            end
        endcase
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;

        // ascii extremes, two and four byte extremes
        drive_byte(8'h00, 1'b0);
        drive_byte(8'h7F, 1'b1);
        drive_byte(8'hC2, 1'b0);
        drive_byte(8'h80, 1'b0);
        drive_byte(8'hF4, 1'b0);
        drive_byte(8'h8F, 1'b0);
        drive_byte(8'hBF, 1'b0);
        drive_byte(8'hBF, 1'b0);
        // invalid leads
        drive_byte(8'h80, 1'b0);
        drive_byte(8'hF5, 1'b0);
        // overlong three byte form
        drive_byte(8'hE0, 1'b0);
        drive_byte(8'h9F, 1'b0);
        drive_byte(8'hBF, 1'b0);
        // encoded surrogate
        drive_byte(8'hED, 1'b0);
        drive_byte(8'hA0, 1'b0);
        drive_byte(8'h80, 1'b0);
        // above the top code point
        drive_byte(8'hF4, 1'b0);
        drive_byte(8'h90, 1'b0);
        drive_byte(8'h80, 1'b0);
        drive_byte(8'h80, 1'b0);
        // interrupted by a new lead that is itself cut short by end of text
        drive_byte(8'hF0, 1'b0);
        drive_byte(8'h90, 1'b0);
        drive_byte(8'h80, 1'b0);
        drive_byte(8'hC3, 1'b1);

        // hold off until the directed words have all come out
        push <= 1'b0;
        do @(posedge i_clk); while (sb.due_units.size() != 0);

        // random text, with stretches of back-to-back words on both sides
        bytes_sent = 0;
        while (bytes_sent < RAND_BYTES) begin
            no_idle = ((bytes_sent / 50) % 4 == 2);
            send_piece();
        end
        no_idle = 1'b0;
        push <= 1'b0;

        // drain, then watch for stray words
        do @(posedge i_clk); while (sb.due_units.size() != 0);
        repeat (8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.due_units.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
